// ----- design/gzhp_pkg.sv -----
package gzhp_pkg;

  // Result classes of one byte.
  localparam logic [2:0] CLS_HEADER  = 3'd0;
  localparam logic [2:0] CLS_LAST    = 3'd1;
  localparam logic [2:0] CLS_BAD     = 3'd2;
  localparam logic [2:0] CLS_PAYLOAD = 3'd3;
  localparam logic [2:0] CLS_IGNORED = 3'd4;

  // Magic and method bytes.
  localparam logic [7:0] ID1_BYTE = 8'd31;
  localparam logic [7:0] ID2_BYTE = 8'd139;
  localparam logic [7:0] CM_BYTE  = 8'd8;

  // Flag bit positions within FLG.
  localparam int FL_HCRC    = 1;
  localparam int FL_EXTRA   = 2;
  localparam int FL_NAME    = 3;
  localparam int FL_COMMENT = 4;

  // Bytes of MTIME, XFL and OS, and of the trailer.
  localparam logic [15:0] FIXED_LEN   = 16'd6;
  localparam logic [15:0] HCRC_LEN    = 16'd2;
  localparam logic [32:0] TRAILER_LEN = 33'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } item_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  data_out;
    logic [31:0] header_length;
    logic [31:0] payload_length;
  } result_t;

endpackage

// ----- design/gzhp_in_reg.sv -----
module gzhp_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gzhp_pkg::item_t  in_item,
  output logic             s0_valid,
  output gzhp_pkg::item_t  s0_item,
  input  logic             s0_take
);

  // The register takes a new item whenever it is empty or being emptied.
  assign in_ready = !s0_valid || s0_take;

  // Valid flag of the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  // Payload of the input stage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item <= in_item;
    end
  end

endmodule

// ----- design/gzhp_parse.sv -----
module gzhp_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  gzhp_pkg::item_t    item,
  input  logic [31:0]        file_size,
  output gzhp_pkg::result_t  result
);

  typedef enum logic [3:0] {
    PH_ID1     = 4'd0,
    PH_ID2     = 4'd1,
    PH_CM      = 4'd2,
    PH_FLG     = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLO     = 4'd5,
    PH_XHI     = 4'd6,
    PH_EXTRA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_PAYLOAD = 4'd11,
    PH_ERROR   = 4'd12
  } phase_t;

  phase_t       phase, phase_next;
  logic         magic_ok, magic_ok_next;
  logic [4:0]   header_flags, header_flags_next;
  logic [15:0]  skip_count, skip_count_next;
  logic [31:0]  header_bytes, header_bytes_next;

  phase_t       ph;
  logic         mok;
  logic [4:0]   flg;
  logic [15:0]  skip;
  logic [15:0]  skip_dec;
  logic [31:0]  hb;
  logic         in_header;
  logic [2:0]   cls;
  logic [32:0]  used;
  logic [32:0]  fs_wide;
  logic [31:0]  plen;

  // Next enabled section after the one just completed.
  function automatic phase_t next_section(input phase_t done, input logic [4:0] flags);
    phase_t nxt;
    if (done < PH_XLO && flags[gzhp_pkg::FL_EXTRA]) begin
      nxt = PH_XLO;
    end else if (done < PH_NAME && flags[gzhp_pkg::FL_NAME]) begin
      nxt = PH_NAME;
    end else if (done < PH_COMMENT && flags[gzhp_pkg::FL_COMMENT]) begin
      nxt = PH_COMMENT;
    end else if (done < PH_HCRC && flags[gzhp_pkg::FL_HCRC]) begin
      nxt = PH_HCRC;
    end else begin
      nxt = PH_PAYLOAD;
    end
    return nxt;
  endfunction

  // A stream start restarts the parser before the byte is looked at.
  always_comb begin
    ph   = item.stream_start ? PH_ID1 : phase;
    mok  = item.stream_start ? 1'b1 : magic_ok;
    flg  = item.stream_start ? 5'd0 : header_flags;
    skip = item.stream_start ? 16'd0 : skip_count;
    hb   = item.stream_start ? 32'd0 : header_bytes;
  end

  assign skip_dec = skip - 16'd1;

  // Per-byte header walk.
  always_comb begin
    phase_next        = ph;
    magic_ok_next     = mok;
    header_flags_next = flg;
    skip_count_next   = skip;
    header_bytes_next = hb;
    in_header         = 1'b0;
    cls               = gzhp_pkg::CLS_HEADER;
    unique case (ph)
      PH_PAYLOAD: begin
        cls = gzhp_pkg::CLS_PAYLOAD;
      end
      PH_ID1, PH_ID2, PH_CM, PH_FLG, PH_FIXED, PH_XLO, PH_XHI,
      PH_EXTRA, PH_NAME, PH_COMMENT, PH_HCRC: begin
        in_header = 1'b1;
        if (hb != 32'hFFFF_FFFF) begin
          header_bytes_next = hb + 32'd1;
        end
        unique case (ph)
          PH_ID1: begin
            if (item.data_byte != gzhp_pkg::ID1_BYTE) magic_ok_next = 1'b0;
            phase_next = PH_ID2;
          end
          PH_ID2: begin
            if (item.data_byte != gzhp_pkg::ID2_BYTE) magic_ok_next = 1'b0;
            phase_next = PH_CM;
          end
          PH_CM: begin
            if (item.data_byte != gzhp_pkg::CM_BYTE || !mok) begin
              magic_ok_next = 1'b0;
              cls           = gzhp_pkg::CLS_BAD;
              phase_next    = PH_ERROR;
            end else begin
              phase_next = PH_FLG;
            end
          end
          PH_FLG: begin
            header_flags_next = item.data_byte[4:0];
            skip_count_next   = gzhp_pkg::FIXED_LEN;
            phase_next        = PH_FIXED;
          end
          PH_XLO: begin
            skip_count_next = {8'd0, item.data_byte};
            phase_next      = PH_XHI;
          end
          PH_XHI: begin
            skip_count_next = {item.data_byte, skip[7:0]};
            if ({item.data_byte, skip[7:0]} == 16'd0) begin
              phase_next = next_section(PH_EXTRA, flg);
            end else begin
              phase_next = PH_EXTRA;
            end
          end
          PH_NAME, PH_COMMENT: begin
            if (item.data_byte == 8'd0) phase_next = next_section(ph, flg);
          end
          default: begin
            // Counted skips: fixed fields, extra field and header CRC.
            skip_count_next = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_next = next_section((ph == PH_FIXED) ? PH_FIXED : ph, flg);
            end
          end
        endcase
        if (phase_next == PH_HCRC && ph != PH_HCRC) begin
          skip_count_next = gzhp_pkg::HCRC_LEN;
        end
        if (phase_next == PH_PAYLOAD) begin
          cls = gzhp_pkg::CLS_LAST;
        end
      end
      default: begin
        // Error phase, and codes that are never reached.
        phase_next = PH_ERROR;
        cls        = gzhp_pkg::CLS_IGNORED;
      end
    endcase
  end

  // Payload length on the last header byte, floored at zero.
  always_comb begin
    used    = {1'b0, header_bytes_next} + gzhp_pkg::TRAILER_LEN;
    fs_wide = {1'b0, file_size};
    plen    = 32'd0;
    if (in_header && phase_next == PH_PAYLOAD && fs_wide > used) begin
      plen = 32'(fs_wide - used);
    end
  end

  assign result.byte_class     = cls;
  assign result.data_out       = item.data_byte;
  assign result.header_length  = header_bytes_next;
  assign result.payload_length = plen;

  // Parser state, updated as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID1;
      magic_ok     <= 1'b1;
      header_flags <= 5'd0;
      skip_count   <= 16'd0;
      header_bytes <= 32'd0;
    end else if (fire) begin
      phase        <= phase_next;
      magic_ok     <= magic_ok_next;
      header_flags <= header_flags_next;
      skip_count   <= skip_count_next;
      header_bytes <= header_bytes_next;
    end
  end

endmodule

// ----- design/gzhp_out_reg.sv -----
module gzhp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  gzhp_pkg::result_t  res_in,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output gzhp_pkg::result_t  res_out
);

  // The register can be loaded when empty or while its item is taken.
  assign space = !out_valid || out_ready;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- design/gzip_header_parser.sv -----
// gzip member header parser. Bytes of a gzip file enter one per cycle on the
// input channel while the result channel is not stalled, and each gives exactly
// one result. The result passes through the input register, then the result
// register, before it is offered on the result channel. A new byte may be
// accepted in every cycle unless the result channel stalls; the parser state
// loop walks the RFC 1952 header and updates as a byte moves from the input
// register to the result register. The file_size register is to be written
// through the cfg channel while the block is idle (the block itself does not
// enforce this) and is used for the payload length reported on the last
// header byte.
module gzip_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        stream_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  byte_class,
  output logic [7:0]  data_out,
  output logic [31:0] header_length,
  output logic [31:0] payload_length
);

  logic               s0_valid;
  gzhp_pkg::item_t    in_item;
  gzhp_pkg::item_t    s0_item;
  gzhp_pkg::result_t  res_next;
  gzhp_pkg::result_t  res;
  logic               space;
  logic               s0_take;
  logic [31:0]        file_size;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= 32'd0;
    end else if (cfg_valid) begin
      file_size <= cfg_data;
    end
  end

  assign in_item.data_byte    = data_byte;
  assign in_item.stream_start = stream_start;

  // An item moves on when the result register has room.
  assign s0_take = s0_valid && space;

  gzhp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s0_valid (s0_valid),
    .s0_item  (s0_item),
    .s0_take  (s0_take)
  );

  gzhp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (s0_take),
    .item      (s0_item),
    .file_size (file_size),
    .result    (res_next)
  );

  gzhp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (s0_take),
    .res_in    (res_next),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res)
  );

  assign byte_class     = res.byte_class;
  assign data_out       = res.data_out;
  assign header_length  = res.header_length;
  assign payload_length = res.payload_length;

endmodule

// ----- design/gzhp_checker.sv -----
module gzhp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  byte_class,
  input  logic [7:0]  data_out,
  input  logic [31:0] header_length,
  input  logic [31:0] payload_length
);

  // A stalled item keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_class) && $stable(data_out)
      && $stable(header_length) && $stable(payload_length))
    else $error("result changed while stalled");

  // A payload length is reported only on the last header byte.
  a_plen_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_class != gzhp_pkg::CLS_LAST |-> payload_length == 32'd0)
    else $error("payload length outside last header byte");

  // Every header byte has been counted.
  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_class == gzhp_pkg::CLS_HEADER || byte_class == gzhp_pkg::CLS_LAST
      || byte_class == gzhp_pkg::CLS_BAD) |-> header_length != 32'd0)
    else $error("header byte with zero header length");

  // A bad magic item always carries a header length of exactly three.
  a_bad_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_class == gzhp_pkg::CLS_BAD |-> header_length == 32'd3)
    else $error("bad magic reported away from the method byte");

  // No result is shown straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind gzip_header_parser gzhp_checker u_gzhp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .byte_class     (byte_class),
  .data_out       (data_out),
  .header_length  (header_length),
  .payload_length (payload_length)
);

// ----- sim/tb.sv -----
module tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 1800;
  localparam int SETTLE_CYCLES = 4;

  // Where the parser stands within one gzip member header.
  typedef enum logic [3:0] {
    ST_MAGIC1, ST_MAGIC2, ST_METHOD, ST_FLAGS, ST_FIXED, ST_XLEN_LO, ST_XLEN_HI,
    ST_EXTRA, ST_NAME, ST_COMMENT, ST_HCRC, ST_PAYLOAD, ST_ERROR
  } hdr_state_t;

  // Patterns of back-pressure on the result channel.
  typedef enum logic [1:0] {
    STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY
  } stall_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte    = '0;
  logic        stream_start = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [2:0]  byte_class;
  logic [7:0]  data_out;
  logic [31:0] header_length;
  logic [31:0] payload_length;

  gzip_header_parser u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .stream_start   (stream_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_class     (byte_class),
    .data_out       (data_out),
    .header_length  (header_length),
    .payload_length (payload_length)
  );

  // Our own copy of the parser state and of the file size register.
  hdr_state_t  hdr_state  = ST_MAGIC1;
  logic        magic_good = 1'b1;
  logic [4:0]  flg_bits   = '0;
  logic [15:0] skip_left  = '0;
  logic [31:0] hdr_count  = '0;
  logic [31:0] size_reg   = '0;

  gzhp_pkg::result_t predicted_results[$];
  int      errors     = 0;
  int      bytes_sent = 0;
  int      burst_left = 0;
  stall_t  stall_mode = STALL_NONE;
  int      mode_left  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void rewind_parser();
    hdr_state  = ST_MAGIC1;
    magic_good = 1'b1;
    flg_bits   = '0;
    skip_left  = '0;
    hdr_count  = '0;
  endfunction

  // Jump to the first section after the finished one that FLG enables.
  function automatic void leave_section(input hdr_state_t done);
    if (done < ST_XLEN_LO && flg_bits[gzhp_pkg::FL_EXTRA]) begin
      hdr_state = ST_XLEN_LO;
    end else if (done < ST_NAME && flg_bits[gzhp_pkg::FL_NAME]) begin
      hdr_state = ST_NAME;
    end else if (done < ST_COMMENT && flg_bits[gzhp_pkg::FL_COMMENT]) begin
      hdr_state = ST_COMMENT;
    end else if (done < ST_HCRC && flg_bits[gzhp_pkg::FL_HCRC]) begin
      hdr_state = ST_HCRC;
      skip_left = gzhp_pkg::HCRC_LEN;
    end else begin
      hdr_state = ST_PAYLOAD;
    end
  endfunction

  // Advance the header walk by one byte and return the result it should give.
  function automatic gzhp_pkg::result_t classify_byte(input logic [7:0] b, input logic st);
    gzhp_pkg::result_t r;
    logic [32:0]       used;
    r = '0;
    r.data_out = b;
    r.byte_class = gzhp_pkg::CLS_HEADER;
    if (st) rewind_parser();
    if (hdr_state == ST_PAYLOAD) begin
      r.byte_class = gzhp_pkg::CLS_PAYLOAD;
    end else if (hdr_state > ST_PAYLOAD) begin
      hdr_state = ST_ERROR;
      r.byte_class = gzhp_pkg::CLS_IGNORED;
    end else begin
      if (hdr_count != '1) hdr_count++;
      case (hdr_state)
        ST_MAGIC1: begin
          if (b != gzhp_pkg::ID1_BYTE) magic_good = 1'b0;
          hdr_state = ST_MAGIC2;
        end
        ST_MAGIC2: begin
          if (b != gzhp_pkg::ID2_BYTE) magic_good = 1'b0;
          hdr_state = ST_METHOD;
        end
        ST_METHOD: begin
          if (b != gzhp_pkg::CM_BYTE) magic_good = 1'b0;
          if (!magic_good) begin
            r.byte_class = gzhp_pkg::CLS_BAD;
            hdr_state = ST_ERROR;
          end else begin
            hdr_state = ST_FLAGS;
          end
        end
        ST_FLAGS: begin
          flg_bits = b[4:0];
          skip_left = gzhp_pkg::FIXED_LEN;
          hdr_state = ST_FIXED;
        end
        ST_FIXED: begin
          skip_left--;
          if (skip_left == '0) leave_section(ST_FIXED);
        end
        ST_XLEN_LO: begin
          skip_left = {8'd0, b};
          hdr_state = ST_XLEN_HI;
        end
        ST_XLEN_HI: begin
          skip_left[15:8] = b;
          if (skip_left == '0) leave_section(ST_EXTRA);
          else hdr_state = ST_EXTRA;
        end
        ST_EXTRA: begin
          skip_left--;
          if (skip_left == '0) leave_section(ST_EXTRA);
        end
        ST_NAME: begin
          if (b == 8'd0) leave_section(ST_NAME);
        end
        ST_COMMENT: begin
          if (b == 8'd0) leave_section(ST_COMMENT);
        end
        default: begin
          skip_left--;
          if (skip_left == '0) leave_section(ST_HCRC);
        end
      endcase
      // The byte that completes the header carries the payload length.
      if (hdr_state == ST_PAYLOAD) begin
        used = {1'b0, hdr_count} + gzhp_pkg::TRAILER_LEN;
        r.byte_class = gzhp_pkg::CLS_LAST;
        r.payload_length = ({1'b0, size_reg} > used) ? size_reg - used[31:0] : '0;
      end
    end
    r.header_length = hdr_count;
    return r;
  endfunction

  // Offer one item, with a random idle gap, possibly none, at the start of each burst.
  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    data_byte    <= b;
    stream_start <= st;
    do @(posedge clk); while (!in_ready);
    predicted_results.push_back(classify_byte(b, st));
    bytes_sent++;
  endtask

  // Let the block drain, then write the file size register.
  task automatic write_file_size(input logic [31:0] v);
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
    burst_left = 0;
  endtask

  // Build one gzip member with random flags and contents, optionally broken.
  task automatic send_member(input bit with_start, input bit corrupt);
    logic [7:0] bytes[$];
    logic [7:0] flags;
    int         n;
    int         cut;
    flags = 8'($urandom_range(0, 255));
    bytes = '{gzhp_pkg::ID1_BYTE, gzhp_pkg::ID2_BYTE, gzhp_pkg::CM_BYTE, flags};
    repeat (gzhp_pkg::FIXED_LEN) bytes.push_back(8'($urandom_range(0, 255)));
    if (flags[gzhp_pkg::FL_EXTRA]) begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = $urandom_range(256, 520);
        default: n = $urandom_range(1, 12);
      endcase
      bytes.push_back(n[7:0]);
      bytes.push_back(n[15:8]);
      repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (flags[gzhp_pkg::FL_NAME]) begin
      repeat ($urandom_range(0, 6)) bytes.push_back(8'($urandom_range(1, 255)));
      bytes.push_back(8'd0);
    end
    if (flags[gzhp_pkg::FL_COMMENT]) begin
      repeat ($urandom_range(0, 6)) bytes.push_back(8'($urandom_range(1, 255)));
      bytes.push_back(8'd0);
    end
    if (flags[gzhp_pkg::FL_HCRC]) begin
      repeat (gzhp_pkg::HCRC_LEN) bytes.push_back(8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 16)) bytes.push_back(8'($urandom_range(0, 255)));
    // Either spoil one magic or method byte or cut the member short.
    if (corrupt) begin
      if ($urandom_range(0, 1) == 1) begin
        n = $urandom_range(0, 2);
        bytes[n] = bytes[n] ^ 8'($urandom_range(1, 255));
      end else begin
        cut = $urandom_range(1, bytes.size());
        bytes = bytes[0:cut-1];
      end
    end
    foreach (bytes[i]) send_byte(bytes[i], with_start && i == 0);
  endtask

  // A mismatch in the method byte or in a magic byte shows only on the method byte.
  task automatic test_bad_magic();
    send_byte(gzhp_pkg::ID1_BYTE, 1'b0);
    send_byte(gzhp_pkg::ID2_BYTE, 1'b0);
    send_byte(gzhp_pkg::CM_BYTE - 8'd1, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(gzhp_pkg::ID2_BYTE, 1'b0);
    send_byte(gzhp_pkg::CM_BYTE, 1'b0);
    send_byte(gzhp_pkg::ID1_BYTE, 1'b0);
  endtask

  // Every flag set, reserved bits too, with an empty extra field, name and comment.
  task automatic test_full_header();
    logic [7:0] bytes[$];
    write_file_size('1);
    bytes = '{gzhp_pkg::ID1_BYTE, gzhp_pkg::ID2_BYTE, gzhp_pkg::CM_BYTE, 8'hFF,
              8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'hFF, 8'h00};
    foreach (bytes[i]) send_byte(bytes[i], i == 0);
  endtask

  // Mostly well-formed members under varying file sizes, with some noise.
  task automatic test_random_streams();
    int target;
    int pick;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      case ($urandom_range(0, 5))
        0:       write_file_size('0);
        1:       write_file_size('1);
        2:       write_file_size($urandom);
        default: write_file_size($urandom_range(0, 80));
      endcase
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          send_member(1'b1, 1'b0);
        end else if (pick < 16) begin
          send_member(1'b1, 1'b1);
        end else if (pick < 17) begin
          send_member(1'b0, 1'b0);
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
          end
        end
      end
    end
  endtask

  // The result channel stalls on a pattern that changes every so often.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_ready <= 1'b1;
      STALL_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: out_ready <= (mode_left % 3 != 0);
      default:        out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Compare each result taken with the oldest prediction.
  always @(posedge clk) begin : check_results
    gzhp_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $error("unexpected result: class %0d, data %0h", byte_class, data_out);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        check_field("byte_class", 32'(want.byte_class), 32'(byte_class));
        check_field("data_out", 32'(want.data_out), 32'(data_out));
        check_field("header_length", want.header_length, header_length);
        check_field("payload_length", want.payload_length, payload_length);
      end
    end
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_bad_magic();
    test_full_header();
    test_random_streams();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/gzhp_pkg.sv
design/gzhp_in_reg.sv
design/gzhp_parse.sv
design/gzhp_out_reg.sv
design/gzip_header_parser.sv
design/gzhp_checker.sv
sim/tb.sv
